[hdl/lrn_cross_channel_forward_top_defines.svh]
// assertion helpers used by the rtl control block
`ifndef LRN_CROSS_CHANNEL_FORWARD_TOP_DEFINES_SVH
`define LRN_CROSS_CHANNEL_FORWARD_TOP_DEFINES_SVH

// same-cycle implication
`define LRNF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LRNF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/lrnf_pkg.sv]
package lrnf_pkg;

  localparam int MAX_WINDOW_DEF = 9;
  localparam int DATA_WIDTH_DEF = 16;

  localparam int CFG_W   = 24;
  localparam int CIDX_W  = 2;

  localparam logic [CIDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CIDX_W-1:0] REG_ALPHA  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_BIAS   = 2'd2;
  localparam logic [CIDX_W-1:0] REG_BETA   = 2'd3;

  localparam logic [3:0]  WINDOW_RST = 4'd5;
  localparam logic [23:0] ALPHA_RST  = 24'd168;
  localparam logic [23:0] BIAS_RST   = 24'd65536;
  localparam logic [15:0] BETA_RST   = 16'd12288;

  // fixed point of the pow path
  localparam int MUL_CH    = 16;
  localparam int LOG_STEPS = 16;
  localparam int POW_STEPS = 20;
  localparam int LG_W      = 24;
  localparam int Y_W       = 41;

  typedef enum logic [2:0] {
    C_IDLE, C_PUSH, C_NORM, C_EMIT, C_FLUSH
  } ctrl_state_t;

  typedef enum logic [3:0] {
    N_INIT, N_IDLE, N_MUL, N_SCALE, N_LEAD, N_LOG, N_EXPO, N_POW, N_PROD, N_SHIFT
  } norm_state_t;

  typedef struct packed {
    logic load;
    logic push;
    logic flush_step;
    logic start;
    logic load_out;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit_now;
    logic last;
    logic fill_zero;
    logic norm_ready;
    logic norm_done;
    logic out_free;
  } ctrl_stat_t;

endpackage

[hdl/lrn_cross_channel_forward_top.sv]
// cross-channel local response normalisation: channel samples of one position stream in
// (signed q8.8, tlast on the final channel) and each comes out as x * (k + a*sum)^-beta,
// saturated to q8.8; results lag by half the window and the final channel flushes the rest.
// each beat is handled alone: it is taken, the window sum is updated, then an iterative
// power unit forms each result by a 3-slice multiply (at the default widths), a bit-per-cycle
// leading-one search of the scale, a 16-step log2 squaring loop and a 20-step exp2 product
// loop, the last three skipped for a zero sample or zero scale; each flushed channel
// costs one more such pass. after reset the power unit builds its exp2 table by a bit-serial
// square root and takes no beat until then; configuration writes are taken as ever.
module lrn_cross_channel_forward_top
  import lrnf_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [CIDX_W-1:0]               cfg_idx,
  input  logic [CFG_W-1:0]                cfg_data,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0] s_tdata,   // sample
  input  logic                            s_tlast,   // last_channel
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [((DATA_WIDTH+7)/8)*8-1:0] m_tdata,   // normalized
  output logic                            m_tlast    // last_result
);

  localparam int TD_W  = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int SUM_W = 2 * DATA_WIDTH - 1 + $clog2(((MAX_WINDOW - 1) | 1) + 1);

  // configuration registers
  logic [3:0]  window_size;
  logic [23:0] alpha_coef, bias_k;
  logic [15:0] beta_exp;
  logic        win_clear;

  ctrl_cmd_t             cmd;
  ctrl_stat_t            stat;
  logic                  norm_ready, norm_done;
  logic [DATA_WIDTH-1:0] norm_res, norm_src, out_data;
  logic [SUM_W-1:0]      norm_sum;

  // a window change drops the stream state in the same beat
  assign win_clear = cfg_we && (cfg_idx == REG_WINDOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_RST;
      alpha_coef  <= ALPHA_RST;
      bias_k      <= BIAS_RST;
      beta_exp    <= BETA_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WINDOW: window_size <= cfg_data[3:0];
        REG_ALPHA:  alpha_coef  <= cfg_data[23:0];
        REG_BIAS:   bias_k      <= cfg_data[23:0];
        REG_BETA:   beta_exp    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  lrnf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // window of squares, sample delay line and output register
  lrnf_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .window_size (window_size),
    .win_clear   (win_clear),
    .in_sample   (s_tdata[DATA_WIDTH-1:0]),
    .in_last     (s_tlast),
    .norm_ready  (norm_ready),
    .norm_done   (norm_done),
    .norm_res    (norm_res),
    .norm_src    (norm_src),
    .norm_sum    (norm_sum),
    .stat        (stat),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_data    (out_data),
    .out_last    (m_tlast)
  );

  // iterative scale^-beta unit
  lrnf_norm #(
    .DATA_WIDTH (DATA_WIDTH),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_norm (
    .clk        (clk),
    .rst        (rst),
    .start      (cmd.start),
    .src        (norm_src),
    .sum        (norm_sum),
    .alpha_coef (alpha_coef),
    .bias_k     (bias_k),
    .beta_exp   (beta_exp),
    .ready      (norm_ready),
    .done       (norm_done),
    .res        (norm_res)
  );

  assign m_tdata = TD_W'(out_data);

endmodule

[hdl/lrnf_ctrl.sv]
`include "lrn_cross_channel_forward_top_defines.svh"

module lrnf_ctrl
  import lrnf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      C_IDLE: begin
        in_ready = stat.norm_ready;
        if (in_valid && stat.norm_ready) begin
          cmd.load   = 1'b1;
          state_next = C_PUSH;
        end
      end
      C_PUSH: begin
        cmd.push = 1'b1;
        if (stat.emit_now) begin
          cmd.start  = 1'b1;
          state_next = C_NORM;
        end else if (stat.last) begin
          state_next = C_FLUSH;
        end else begin
          state_next = C_IDLE;
        end
      end
      C_NORM: begin
        if (stat.norm_done) state_next = C_EMIT;
      end
      C_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = stat.last ? C_FLUSH : C_IDLE;
        end
      end
      C_FLUSH: begin
        if (stat.fill_zero) begin
          cmd.clear  = 1'b1;
          state_next = C_IDLE;
        end else begin
          cmd.flush_step = 1'b1;
          cmd.start      = 1'b1;
          state_next     = C_NORM;
        end
      end
      default: state_next = C_IDLE;
    endcase
  end

  `LRNF_ASSERT_IMP(a_start_idle, cmd.start, stat.norm_ready, "normaliser started while busy")
  `LRNF_ASSERT_IMP(a_load_free, cmd.load_out, stat.out_free, "output register overwritten")
  `LRNF_ASSERT_NXT(a_accept_push, in_valid && in_ready, state == C_PUSH, "accept without push")

endmodule

[hdl/lrnf_dp.sv]
module lrnf_dp
  import lrnf_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ctrl_cmd_t               cmd,
  input  logic [3:0]              window_size,
  input  logic                    win_clear,
  input  logic [DATA_WIDTH-1:0]   in_sample,
  input  logic                    in_last,
  input  logic                    norm_ready,
  input  logic                    norm_done,
  input  logic [DATA_WIDTH-1:0]   norm_res,
  output logic [DATA_WIDTH-1:0]   norm_src,
  output logic [2*DATA_WIDTH-1+$clog2(((MAX_WINDOW-1)|1)+1)-1:0] norm_sum,
  output ctrl_stat_t              stat,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [DATA_WIDTH-1:0]   out_data,
  output logic                    out_last
);

  localparam int WIN_CAP  = (MAX_WINDOW - 1) | 1;
  localparam int HALF_CAP = (WIN_CAP - 1) / 2;
  localparam int DLY_D    = (HALF_CAP > 0) ? HALF_CAP : 1;
  localparam int F_W      = (HALF_CAP > 0) ? $clog2(HALF_CAP + 1) : 1;
  localparam int DLY_IW   = (DLY_D > 1) ? $clog2(DLY_D) : 1;
  localparam int SW_IW    = (WIN_CAP > 1) ? $clog2(WIN_CAP) : 1;
  localparam int SUM_W    = 2 * DATA_WIDTH - 1 + $clog2(WIN_CAP + 1);

  logic [DATA_WIDTH-1:0] x_reg;
  logic                  last_reg;
  logic [SUM_W-1:0]      sw [WIN_CAP];
  logic [DATA_WIDTH-1:0] sd [DLY_D];
  logic [SUM_W-1:0]      sum;
  logic [F_W-1:0]        fill;
  logic                  src_last;

  logic [3:0]              w1, w2, w3, tail;
  logic [F_W-1:0]          p, rd_full;
  logic [DATA_WIDTH-1:0]   mag;
  logic [2*DATA_WIDTH-1:0] sq;
  logic [SUM_W-1:0]        sq_in, sum_next;

  // effective odd window and half width
  always_comb begin
    w1   = (window_size == 4'd0) ? 4'd1 : window_size;
    w2   = w1[0] ? w1 : w1 - 4'd1;
    w3   = (w2 > 4'(WIN_CAP)) ? 4'(WIN_CAP) : w2;
    p    = F_W'(w3 >> 1);
    tail = w3 - 4'd1;
  end

  assign mag      = x_reg[DATA_WIDTH-1] ? (~x_reg + 1'b1) : x_reg;
  assign sq       = mag * mag;
  assign sq_in    = cmd.flush_step ? '0 : SUM_W'(sq);
  assign sum_next = sum + sq_in - sw[tail[SW_IW-1:0]];
  assign norm_sum = sum_next;

  // one read port on the delay line
  assign rd_full  = cmd.flush_step ? fill - 1'b1 : p - 1'b1;
  assign norm_src = (!cmd.flush_step && p == '0) ? x_reg : sd[rd_full[DLY_IW-1:0]];

  always_ff @(posedge clk) begin
    if (rst || win_clear || cmd.clear) begin
      for (int i = 0; i < WIN_CAP; i++) sw[i] <= '0;
      for (int i = 0; i < DLY_D; i++) sd[i] <= '0;
      sum  <= '0;
      fill <= '0;
    end else if (cmd.push || cmd.flush_step) begin
      for (int i = WIN_CAP - 1; i > 0; i--) sw[i] <= sw[i-1];
      sw[0] <= sq_in;
      sum   <= sum_next;
      if (cmd.push) begin
        for (int i = DLY_D - 1; i > 0; i--) sd[i] <= sd[i-1];
        sd[0] <= x_reg;
        if (fill < p) fill <= fill + 1'b1;
      end else begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_reg    <= in_sample;
      last_reg <= in_last;
    end
    if (cmd.push) src_last <= last_reg && (p == '0);
    else if (cmd.flush_step) src_last <= (fill == F_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= norm_res;
      out_last <= src_last;
    end
  end

  always_comb begin
    stat.emit_now   = (fill >= p);
    stat.last       = last_reg;
    stat.fill_zero  = (fill == '0);
    stat.norm_ready = norm_ready;
    stat.norm_done  = norm_done;
    stat.out_free   = !out_valid || out_ready;
  end

endmodule

[hdl/lrnf_norm.sv]
module lrnf_norm
  import lrnf_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] src,
  input  logic [2*DATA_WIDTH-1+$clog2(((MAX_WINDOW-1)|1)+1)-1:0] sum,
  input  logic [23:0]           alpha_coef,
  input  logic [23:0]           bias_k,
  input  logic [15:0]           beta_exp,
  output logic                  ready,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] res
);

  localparam int WIN_CAP = (MAX_WINDOW - 1) | 1;
  localparam int SUM_W   = 2 * DATA_WIDTH - 1 + $clog2(WIN_CAP + 1);
  localparam int NCH     = (SUM_W + MUL_CH - 1) / MUL_CH;
  localparam int CI_W    = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int SS_W    = NCH * MUL_CH;
  localparam int ACC_W   = SS_W + 24;
  localparam int SC_W0   = ((SUM_W > 24) ? SUM_W : 24) + 1;
  localparam int SC_W    = (SC_W0 > 31) ? SC_W0 : 31;
  localparam int E_W     = $clog2(SC_W);
  localparam int PROD_W  = DATA_WIDTH + 31;
  localparam int IP_W    = Y_W - 30;

  norm_state_t state, state_next;

  // table of 2^(-2^-(k+1)) in q0.30, built by a bit-serial square root after reset
  logic [30:0] ctab [POW_STEPS];
  logic [4:0]  tk, tbit;
  logic [30:0] troot, tprev, trial;
  logic [61:0] tsq;

  logic                  neg, zs;
  logic [DATA_WIDTH-1:0] mag;
  logic [SS_W-1:0]       ss;
  logic [ACC_W-1:0]      acc;
  logic [CI_W-1:0]       ci;
  logic [SC_W-1:0]       sc, scale_new;
  logic [E_W-1:0]        e;
  logic [30:0]           m, g;
  logic [61:0]           mm, gm;
  logic [31:0]           t;
  logic [15:0]           frac;
  logic [3:0]            li;
  logic [4:0]            pk;
  logic signed [LG_W-1:0] lg;
  logic signed [Y_W-1:0]  y;
  logic [PROD_W-1:0]     prod;
  logic [DATA_WIDTH-1:0] src_mag;

  logic signed [IP_W-1:0] ip;
  logic signed [IP_W:0]   s, sh;
  logic [63:0]            p64, cap64, r64;
  logic [DATA_WIDTH-1:0]  r_fin;

  assign trial     = troot | (31'd1 << tbit);
  assign tsq       = trial * trial;
  assign src_mag   = src[DATA_WIDTH-1] ? (~src + 1'b1) : src;
  assign scale_new = SC_W'(acc[ACC_W-1:24]) + SC_W'(bias_k);
  assign mm        = m * m;
  assign t         = mm[61:30];
  assign gm        = g * ctab[pk];
  assign lg        = $signed(LG_W'({e, 16'h0}) - LG_W'(32'h10_0000) + LG_W'(frac));

  assign ready = (state == N_IDLE);
  assign done  = (state == N_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      N_INIT:  if (tbit == 5'd0 && tk == 5'(POW_STEPS - 1)) state_next = N_IDLE;
      N_IDLE:  if (start) state_next = N_MUL;
      N_MUL:   if (ci == CI_W'(NCH - 1)) state_next = N_SCALE;
      N_SCALE: state_next = (scale_new == '0 || mag == '0) ? N_SHIFT : N_LEAD;
      N_LEAD:  if (sc[SC_W-1]) state_next = N_LOG;
      N_LOG:   if (li == 4'(LOG_STEPS - 1)) state_next = N_EXPO;
      N_EXPO:  state_next = N_POW;
      N_POW:   if (pk == 5'(POW_STEPS - 1)) state_next = N_PROD;
      N_PROD:  state_next = N_SHIFT;
      N_SHIFT: state_next = N_IDLE;
      default: state_next = N_IDLE;
    endcase
  end

  // table build counters
  always_ff @(posedge clk) begin
    if (rst) begin
      tk    <= '0;
      tbit  <= 5'd30;
      troot <= '0;
      tprev <= 31'd1 << 29;
    end else if (state == N_INIT) begin
      if (tbit == 5'd0) begin
        ctab[tk] <= (tsq <= {tprev, 30'b0}) ? trial : troot;
        tprev    <= (tsq <= {tprev, 30'b0}) ? trial : troot;
        troot    <= '0;
        tbit     <= 5'd30;
        tk       <= tk + 5'd1;
      end else begin
        if (tsq <= {tprev, 30'b0}) troot <= trial;
        tbit <= tbit - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      N_IDLE: begin
        if (start) begin
          neg <= src[DATA_WIDTH-1];
          mag <= src_mag;
          ss  <= SS_W'(sum);
          acc <= '0;
          ci  <= '0;
        end
      end
      N_MUL: begin
        // horner over 16-bit slices, top slice first
        acc <= (acc << MUL_CH) + ACC_W'(alpha_coef * ss[SS_W-1 -: MUL_CH]);
        ss  <= ss << MUL_CH;
        ci  <= ci + 1'b1;
      end
      N_SCALE: begin
        sc <= scale_new;
        zs <= (scale_new == '0);
        e  <= E_W'(SC_W - 1);
      end
      N_LEAD: begin
        if (sc[SC_W-1]) begin
          m    <= sc[SC_W-1 -: 31];
          li   <= '0;
          frac <= '0;
        end else begin
          sc <= sc << 1;
          e  <= e - 1'b1;
        end
      end
      N_LOG: begin
        frac <= {frac[14:0], t[31]};
        m    <= t[31] ? t[31:1] : t[30:0];
        li   <= li + 1'b1;
      end
      N_EXPO: begin
        y  <= $signed({1'b0, beta_exp}) * lg;
        g  <= 31'd1 << 30;
        pk <= '0;
      end
      N_POW: begin
        if (y[29 - pk]) g <= gm[60:30];
        pk <= pk + 1'b1;
      end
      N_PROD: begin
        prod <= mag * g;
      end
      N_SHIFT: begin
        res <= neg ? (~r_fin + 1'b1) : r_fin;
      end
      default: ;
    endcase
  end

  // rounding and saturation
  always_comb begin
    ip    = y[Y_W-1:30];
    s     = (IP_W + 1)'(30) + {ip[IP_W-1], ip};
    sh    = -s;
    p64   = 64'(prod);
    cap64 = neg ? (64'd1 << (DATA_WIDTH - 1)) : ((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
    if (mag == '0) begin
      r64 = '0;
    end else if (zs) begin
      r64 = (beta_exp == '0) ? 64'(mag) : cap64;
    end else if (s >= 63) begin
      r64 = '0;
    end else if (s > 0) begin
      r64 = (p64 + (64'd1 << (s[5:0] - 6'd1))) >> s[5:0];
    end else if (s == 0) begin
      r64 = p64;
    end else if (sh >= DATA_WIDTH || p64 > (cap64 >> sh[5:0])) begin
      r64 = cap64;
    end else begin
      r64 = p64 << sh[5:0];
    end
    if (r64 > cap64) r64 = cap64;
    r_fin = r64[DATA_WIDTH-1:0];
  end

endmodule

[verif/lrn_cross_channel_forward_top_test.sv]
`timescale 1ns / 1ps

// scoreboard: mirrors the registers and the channel window, predicts each
// normalised result and checks the result beats in order
class lrn_scoreboard;
  typedef struct {
    logic [15:0] normalized;
    logic        last_result;
  } lrn_result_t;

  lrn_result_t norm_q[$];
  int          errors;

  logic [3:0]  win_reg;
  logic [23:0] alpha_reg;
  logic [23:0] bias_reg;
  logic [15:0] beta_reg;

  bit [63:0]   squares[9];
  longint      delayed[5];
  bit [63:0]   sq_sum;
  int          filled;
  bit [63:0]   exp_fac[21];

  function new();
    bit [63:0] c;
    errors    = 0;
    win_reg   = lrnf_pkg::WINDOW_RST;
    alpha_reg = lrnf_pkg::ALPHA_RST;
    bias_reg  = lrnf_pkg::BIAS_RST;
    beta_reg  = lrnf_pkg::BETA_RST;
    clear_window();
    // factors 2^(-2^-k) in q0.30, each the square root of the one before
    c = 64'd1 << 29;
    for (int k = 1; k <= 20; k++) begin
      c = int_sqrt(c << 30);
      exp_fac[k] = c;
    end
  endfunction

  function bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function void clear_window();
    foreach (squares[i]) squares[i] = 0;
    foreach (delayed[i]) delayed[i] = 0;
    sq_sum = 0;
    filled = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [23:0] val);
    case (idx)
      lrnf_pkg::REG_WINDOW: begin
        win_reg = val[3:0];
        clear_window();
      end
      lrnf_pkg::REG_ALPHA: alpha_reg = val;
      lrnf_pkg::REG_BIAS:  bias_reg  = val;
      lrnf_pkg::REG_BETA:  beta_reg  = val[15:0];
      default: ;
    endcase
  endfunction

  function int window_width();
    int w;
    w = win_reg;
    if (w == 0) w = 1;
    if (w % 2 == 0) w = w - 1;
    if (w > 9) w = 9;
    return w;
  endfunction

  function void push_square(bit [63:0] sq, int w);
    sq_sum = sq_sum + sq - squares[w-1];
    for (int i = w - 1; i > 0; i--) squares[i] = squares[i-1];
    squares[0] = sq;
  endfunction

  // x * (k + a*sum)^-beta via log2 and a product of exp2 factors
  function logic [15:0] scaled_sample(longint x, bit [63:0] sum);
    bit [63:0] cap, mag, scale, r, m, frac, f20, g, prod;
    longint    lg, y, ip, f;
    int        e, s, sh;
    cap = (x < 0) ? 64'd32768 : 64'd32767;
    mag = (x < 0) ? -x : x;
    scale = bias_reg + ((alpha_reg * sum) >> 24);
    if (mag == 0) return 16'd0;
    if (scale == 0) begin
      r = (beta_reg == 0) ? mag : cap;
    end else begin
      e = 63;
      while (scale[e] == 1'b0) e--;
      m = (e >= 30) ? (scale >> (e - 30)) : (scale << (30 - e));
      frac = 0;
      for (int k = 0; k < 16; k++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd1 << 31)) begin
          frac = frac | 1;
          m = m >> 1;
        end
      end
      lg = longint'(e - 16) * 65536 + longint'(frac);
      y  = longint'(beta_reg) * lg;
      if (y >= 0) ip = y >>> 30;
      else ip = -longint'(($unsigned(-y) + ((64'd1 << 30) - 1)) >> 30);
      f   = y - ip * (longint'(1) << 30);
      f20 = $unsigned(f) >> 10;
      g = 64'd1 << 30;
      for (int k = 1; k <= 20; k++)
        if (f20[20-k]) g = (g * exp_fac[k]) >> 30;
      prod = mag * g;
      s = 30 + int'(ip);
      if (s >= 63) r = 0;
      else if (s > 0) r = (prod + (64'd1 << (s - 1))) >> s;
      else if (s == 0) r = prod;
      else begin
        sh = -s;
        if (sh >= 16 || prod > (cap >> sh)) r = cap;
        else r = prod << sh;
      end
    end
    if (r > cap) r = cap;
    return (x < 0) ? 16'(-longint'(r)) : 16'(r);
  endfunction

  function void add_result(longint x, bit last);
    lrn_result_t res;
    res.normalized  = scaled_sample(x, sq_sum);
    res.last_result = last;
    norm_q.insert(norm_q.size(), res);
  endfunction

  // accepted input beat
  function void note_beat(logic [15:0] sample, logic last);
    int        w, p, pend;
    longint    x, src;
    bit [63:0] mag;
    w = window_width();
    p = (w - 1) / 2;
    x = longint'(signed'(sample));
    mag = (x < 0) ? -x : x;
    push_square(mag * mag, w);
    if (filled >= p) begin
      src = (p == 0) ? x : delayed[p-1];
      add_result(src, last && p == 0);
    end
    if (p > 0) begin
      for (int i = p - 1; i > 0; i--) delayed[i] = delayed[i-1];
      delayed[0] = x;
    end
    if (filled < p) filled++;
    if (last) begin
      pend = filled;
      while (pend > 0) begin
        pend--;
        push_square(0, w);
        add_result(delayed[pend], pend == 0);
      end
      clear_window();
    end
  endfunction

  // accepted result beat
  function void check_result(logic [15:0] data, logic last);
    lrn_result_t want;
    if (norm_q.size() == 0) begin
      $display("%0t: unexpected result data %h last %b", $time, data, last);
      errors++;
      return;
    end
    want = norm_q.pop_front();
    if (data !== want.normalized) begin
      $display("%0t: normalized expected %h actual %h", $time, want.normalized, data);
      errors++;
    end
    if (last !== want.last_result) begin
      $display("%0t: last_result expected %b actual %b", $time, want.last_result, last);
      errors++;
    end
  endfunction
endclass

module lrn_cross_channel_forward_top_test;
  import lrnf_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [23:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // sample
  logic        s_tlast;   // last_channel
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // normalized
  logic        m_tlast;   // last_result

  lrn_scoreboard sb;

  // idle percentages of each side, changed per phase
  int send_idle;
  int recv_idle;
  // long receiver hold-off, requested by the stimulus, counted by the receiver
  bit hold_req;
  int hold_left;
  int beats_sent;

  lrn_cross_channel_forward_top u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous ceiling: power-unit table build, up to five results on a last beat, stalls
  initial begin
    #40ms;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: checks result beats and stalls at random or for a long hold
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // one input beat; valid stays high into the next beat unless the sender idles
  task automatic send_beat(logic [15:0] sample, logic last);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sample;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_beat(sample, last);
    beats_sent++;
  endtask

  // wait for every expected result, then for one more pass of the power unit
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.norm_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // write enable is left high; the caller drops it after the last write
  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_all(logic [3:0] w, logic [23:0] a, logic [23:0] k, logic [15:0] b);
    drain();
    write_reg(REG_WINDOW, 24'(w));
    write_reg(REG_ALPHA, a);
    write_reg(REG_BIAS, k);
    write_reg(REG_BETA, 24'(b));
    cfg_we <= 1'b0;
  endtask

  // extremes a quarter of the time each, otherwise a spread value
  function automatic logic [23:0] pick_field(logic [23:0] top, logic [23:0] typ);
    int sel;
    sel = $urandom_range(3);
    if (sel == 0) return 24'd0;
    if (sel == 1) return top;
    if ($urandom_range(1)) return 24'($urandom_range(int'(top)));
    return 24'($urandom_range(int'(typ) * 2));
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(5))
      0, 1: return 16'($urandom);
      2:    return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      default: return 16'($signed($urandom_range(1024)) - 512);
    endcase
  endfunction

  // one position: a run of channels closed by tlast
  task automatic send_position(int nch);
    for (int c = 0; c < nch; c++) send_beat(pick_sample(), c == nch - 1);
  endtask

  task automatic random_phase(int sidle, int ridle, int nbeats, bit with_hold);
    int          goal;
    logic [23:0] fw, fb;
    drain();
    send_idle = sidle;
    recv_idle = ridle;
    goal = beats_sent + nbeats;
    while (beats_sent < goal) begin
      fw = pick_field(24'd15, 24'd5);
      fb = pick_field(24'hffff, 24'd12288);
      set_all(fw[3:0], pick_field(24'hffffff, 24'd168),
              pick_field(24'hffffff, 24'd65536), fb[15:0]);
      repeat (1 + $urandom_range(3)) begin
        // a long hold while the sender keeps going so the block backs up onto its input
        if (with_hold) begin
          hold_req  = 1'b1;
          with_hold = 1'b0;
        end
        send_position($urandom_range(9) == 0 ? $urandom_range(13, 20) : $urandom_range(1, 12));
      end
    end
  endtask

  initial begin
    sb        = new();
    send_idle = 0;
    recv_idle = 0;
    hold_req  = 1'b0;
    hold_left = 0;
    beats_sent = 0;
    rst      <= 1'b1;
    cfg_we   <= 1'b0;
    cfg_idx  <= REG_WINDOW;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    m_tready <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, full-scale and tiny samples over a 5-wide window
    send_beat(16'h8000, 1'b0);
    send_beat(16'h7fff, 1'b0);
    send_beat(16'h0000, 1'b0);
    send_beat(16'h0001, 1'b0);
    send_beat(16'hffff, 1'b0);
    send_beat(16'h0100, 1'b1);
    // short positions, fewer channels than half the window
    send_beat(16'hfe00, 1'b1);
    send_beat(16'h0280, 1'b0);
    send_beat(16'h8001, 1'b1);
    // even window and zero scale with beta zero: samples pass through
    set_all(4'd4, 24'd0, 24'd0, 16'd0);
    send_beat(16'h1234, 1'b0);
    send_beat(16'hedcc, 1'b0);
    send_beat(16'h0000, 1'b1);
    // zero scale with beta nonzero saturates, oversized window
    set_all(4'd15, 24'd0, 24'd0, 16'hffff);
    send_beat(16'h0003, 1'b0);
    send_beat(16'hfffd, 1'b0);
    send_beat(16'h0000, 1'b1);
    // zero window, largest alpha and bias
    set_all(4'd0, 24'hffffff, 24'hffffff, 16'd16384);
    send_beat(16'h7fff, 1'b0);
    send_beat(16'h8000, 1'b1);
    // tiny scale with large beta pushes results to the limits
    set_all(4'd9, 24'd1, 24'd1, 16'hffff);
    send_beat(16'h0040, 1'b0);
    send_beat(16'hffc0, 1'b0);
    send_beat(16'h0000, 1'b0);
    send_beat(16'h0001, 1'b1);

    random_phase(31, 52, 110, 1'b1);
    random_phase(52, 31, 110, 1'b0);
    random_phase(0, 0, 110, 1'b0);

    drain();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
